FILE: hw/rtl/mmcc_pkg.sv
package mmcc_pkg;

    localparam logic [2:0] MODE_PARITY   = 3'd0;
    localparam logic [2:0] MODE_CRC8     = 3'd1;
    localparam logic [2:0] MODE_CRC16    = 3'd2;
    localparam logic [2:0] MODE_CRC32    = 3'd3;
    localparam logic [2:0] MODE_INETSUM  = 3'd4;
    localparam logic [2:0] MODE_RESET    = MODE_CRC32;

    localparam logic [1:0] SEL_PARITY = 2'd0;
    localparam logic [1:0] SEL_CRC8   = 2'd1;
    localparam logic [1:0] SEL_CRC16  = 2'd2;
    localparam logic [1:0] SEL_CRC32  = 2'd3;

    localparam logic [31:0] POLY_PARITY = 32'h0000_0001;
    localparam logic [31:0] POLY_CRC8   = 32'h0000_0007;
    localparam logic [31:0] POLY_CRC16  = 32'h0000_8101;
    localparam logic [31:0] POLY_CRC32  = 32'h04C1_1DB7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_req;

    typedef struct packed {
        logic [31:0] check_value;
        logic        value_is_zero;
    } t_out_req;

    typedef struct packed {
        logic [31:0] shift_register;
        logic [15:0] sum_accumulator;
        logic [7:0]  held_high_byte;
        logic        odd_byte_phase;
    } t_msg_state;

    // Eight MSB-first LFSR steps of the selected width.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data,
                                             input logic [1:0]  sel);
        logic [31:0] mask;
        logic [31:0] poly;
        logic [4:0]  top;
        logic [31:0] crc;
        logic        fb;
        unique case (sel)
            SEL_PARITY: begin
                mask = 32'h0000_0001; poly = POLY_PARITY; top = 5'd0;
            end
            SEL_CRC8: begin
                mask = 32'h0000_00FF; poly = POLY_CRC8;   top = 5'd7;
            end
            SEL_CRC16: begin
                mask = 32'h0000_FFFF; poly = POLY_CRC16;  top = 5'd15;
            end
            default: begin
                mask = 32'hFFFF_FFFF; poly = POLY_CRC32;  top = 5'd31;
            end
        endcase
        crc = crc_in & mask;
        for (int b = 7; b >= 0; b--) begin
            fb  = crc[top] ^ data[b];
            crc = (crc << 1) & mask;
            if (fb) begin
                crc = crc ^ poly;
            end
        end
        return crc;
    endfunction

endpackage

FILE: hw/rtl/mmcc_engine.sv
module mmcc_engine
    import mmcc_pkg::*;
(
    input  logic [2:0] i_mode,
    input  t_in_req    i_req,
    input  t_msg_state i_state,
    output t_msg_state o_state,
    output t_out_req   o_res
);

    logic [1:0]  sel;
    logic [15:0] word;
    logic [16:0] raw_sum;
    logic [15:0] folded_sum;
    logic [31:0] crc_next;
    logic [31:0] result;
    t_msg_state  upd;

    always_comb begin
        unique case (i_mode)
            MODE_PARITY: sel = SEL_PARITY;
            MODE_CRC8:   sel = SEL_CRC8;
            MODE_CRC16:  sel = SEL_CRC16;
            default:     sel = SEL_CRC32;
        endcase
    end

    assign crc_next = crc_byte(i_state.shift_register, i_req.data_byte, sel);

    // Odd trailing byte pads with a zero low byte.
    assign word       = i_state.odd_byte_phase ? {i_state.held_high_byte, i_req.data_byte}
                                               : {i_req.data_byte, 8'h00};
    assign raw_sum    = {1'b0, i_state.sum_accumulator} + {1'b0, word};
    assign folded_sum = raw_sum[15:0] + {15'd0, raw_sum[16]};

    always_comb begin
        upd    = i_state;
        result = 32'd0;
        if (i_mode == MODE_INETSUM) begin
            if (!i_state.odd_byte_phase && !i_req.last_byte) begin
                upd.held_high_byte = i_req.data_byte;
                upd.odd_byte_phase = 1'b1;
            end else begin
                upd.sum_accumulator = folded_sum;
                upd.held_high_byte  = 8'd0;
                upd.odd_byte_phase  = 1'b0;
            end
            result = {16'd0, ~upd.sum_accumulator};
        end else begin
            upd.shift_register = crc_next;
            result             = crc_next;
        end
    end

    // End of message: clear everything, drop any held byte.
    assign o_state = i_req.last_byte ? '0 : upd;

    assign o_res.check_value   = result;
    assign o_res.value_is_zero = (result == 32'd0);

endmodule

FILE: hw/rtl/multi_mode_crc_checksum_core.sv
// channel  | direction | handshake                     | payload
// ---------+-----------+-------------------------------+--------------------------
// in       | input     | i_in_valid / o_in_stall       | i_in_req  (t_in_req)
// out      | output    | o_out_valid / i_out_stall     | o_out_req (t_out_req)
// cfg      | input     | i_cfg_valid / o_cfg_ready     | i_cfg_data (check mode)
//
// One byte per cycle while o_in_stall is low: the CRC byte step (eight unrolled LFSR
// shifts) or one 16-bit end-around-carry add sits between the message state registers
// and the result register. A result lands there, or in the skid if the output stalls.
// A two-entry output stage (result register plus skid) keeps o_in_stall registered.
// Synchronous active-low reset: mode CRC-32, message state cleared, output empty.
module multi_mode_crc_checksum_core
    import mmcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_req    i_in_req,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_req   o_out_req,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_data
);

    logic [2:0]  r_mode;
    t_msg_state  r_state;
    t_msg_state  n_state;
    t_out_req    n_res;
    t_out_req    r_out;
    t_out_req    r_skid;
    logic        r_out_valid;
    logic        r_skid_valid;
    logic        accept;
    logic        push;
    logic        out_free;

    mmcc_engine u_engine (
        .i_mode  (r_mode),
        .i_req   (i_in_req),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (n_res)
    );

    assign accept   = i_in_valid && !r_skid_valid;
    assign push     = accept && i_in_req.last_byte;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_RESET;
            r_state      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (accept) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid  <= r_skid_valid || push;
                r_skid_valid <= 1'b0;
            end else if (push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (push) begin
                r_out <= n_res;
            end
        end else if (push) begin
            r_skid <= n_res;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;
    assign o_cfg_ready = 1'b1;

endmodule
